### rtl/pftb_pkg.sv
package pftb_pkg;

  typedef enum logic [3:0] {
    FMT_ARGB8   = 4'd0,
    FMT_XRGB8   = 4'd1,
    FMT_ABGR8   = 4'd2,
    FMT_XBGR8   = 4'd3,
    FMT_A2RGB10 = 4'd4,
    FMT_A2BGR10 = 4'd5,
    FMT_RGB565  = 4'd6,
    FMT_A1RGB5  = 4'd7,
    FMT_X1RGB5  = 4'd8,
    FMT_ARGB4   = 4'd9,
    FMT_A8L8    = 4'd10,
    FMT_A8      = 4'd11,
    FMT_L8      = 4'd12
  } fmt_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgra_t;

  localparam int unsigned RegFmtIndex = 0;
  localparam int unsigned FmtWidth    = 4;

  // Widens an n-bit channel to 8 bits as round(v*255/(2^n-1)). The division by
  // 2^n-1 folds the high part back onto the low part a few times, which leaves
  // a remainder below twice the divisor, so one compare finishes it.
  function automatic logic [7:0] widen(input logic [9:0] v, input int unsigned bits);
    logic [9:0]  m;
    logic [19:0] y;
    logic [19:0] hi;
    logic [8:0]  q;
    m = 10'((20'd1 << bits) - 20'd1);
    y = ((20'(v & m) * 20'd510) + 20'(m)) >> 1;
    q = 9'd0;
    for (int i = 0; i < 4; i++) begin
      hi = y >> bits;
      q  = q + hi[8:0];
      y  = hi + (y & 20'(m));
    end
    if (y >= 20'(m)) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

endpackage

### rtl/pftb_regs.sv
module pftb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [pftb_pkg::FmtWidth-1:0]  pixel_format
);

  logic fmt_sel;

  assign pready  = 1'b1;
  assign fmt_sel = (32'(paddr[2]) == pftb_pkg::RegFmtIndex);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= '0;
    end else if (psel && penable && pwrite && fmt_sel) begin
      pixel_format <= pwdata[pftb_pkg::FmtWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (fmt_sel) begin
      prdata[pftb_pkg::FmtWidth-1:0] = pixel_format;
    end
  end

endmodule

### rtl/pftb_convert.sv
module pftb_convert (
  input  logic [pftb_pkg::FmtWidth-1:0] pixel_format,
  input  logic [31:0]                   raw_pixel,
  output pftb_pkg::bgra_t               pixel
);

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;

  assign b0 = raw_pixel[7:0];
  assign b1 = raw_pixel[15:8];
  assign b2 = raw_pixel[23:16];
  assign b3 = raw_pixel[31:24];

  always_comb begin
    pixel = '0;
    unique case (pixel_format)
      pftb_pkg::FMT_ARGB8: begin
        pixel.blue  = b0;
        pixel.green = b1;
        pixel.red   = b2;
        pixel.alpha = b3;
      end
      pftb_pkg::FMT_XRGB8: begin
        pixel.blue  = b0;
        pixel.green = b1;
        pixel.red   = b2;
        pixel.alpha = 8'hff;
      end
      pftb_pkg::FMT_ABGR8: begin
        pixel.red   = b0;
        pixel.green = b1;
        pixel.blue  = b2;
        pixel.alpha = b3;
      end
      pftb_pkg::FMT_XBGR8: begin
        pixel.red   = b0;
        pixel.green = b1;
        pixel.blue  = b2;
        pixel.alpha = 8'hff;
      end
      pftb_pkg::FMT_A2RGB10: begin
        pixel.red   = pftb_pkg::widen(raw_pixel[29:20], 10);
        pixel.green = pftb_pkg::widen(raw_pixel[19:10], 10);
        pixel.blue  = pftb_pkg::widen(raw_pixel[9:0], 10);
        pixel.alpha = pftb_pkg::widen({8'd0, raw_pixel[31:30]}, 2);
      end
      pftb_pkg::FMT_A2BGR10: begin
        pixel.red   = pftb_pkg::widen(raw_pixel[9:0], 10);
        pixel.green = pftb_pkg::widen(raw_pixel[19:10], 10);
        pixel.blue  = pftb_pkg::widen(raw_pixel[29:20], 10);
        pixel.alpha = pftb_pkg::widen({8'd0, raw_pixel[31:30]}, 2);
      end
      pftb_pkg::FMT_RGB565: begin
        pixel.red   = pftb_pkg::widen({5'd0, raw_pixel[15:11]}, 5);
        pixel.green = pftb_pkg::widen({4'd0, raw_pixel[10:5]}, 6);
        pixel.blue  = pftb_pkg::widen({5'd0, raw_pixel[4:0]}, 5);
        pixel.alpha = 8'hff;
      end
      pftb_pkg::FMT_A1RGB5: begin
        pixel.red   = pftb_pkg::widen({5'd0, raw_pixel[14:10]}, 5);
        pixel.green = pftb_pkg::widen({5'd0, raw_pixel[9:5]}, 5);
        pixel.blue  = pftb_pkg::widen({5'd0, raw_pixel[4:0]}, 5);
        pixel.alpha = {8{raw_pixel[15]}};
      end
      pftb_pkg::FMT_X1RGB5: begin
        pixel.red   = pftb_pkg::widen({5'd0, raw_pixel[14:10]}, 5);
        pixel.green = pftb_pkg::widen({5'd0, raw_pixel[9:5]}, 5);
        pixel.blue  = pftb_pkg::widen({5'd0, raw_pixel[4:0]}, 5);
        pixel.alpha = 8'hff;
      end
      pftb_pkg::FMT_ARGB4: begin
        pixel.red   = pftb_pkg::widen({6'd0, raw_pixel[11:8]}, 4);
        pixel.green = pftb_pkg::widen({6'd0, raw_pixel[7:4]}, 4);
        pixel.blue  = pftb_pkg::widen({6'd0, raw_pixel[3:0]}, 4);
        pixel.alpha = pftb_pkg::widen({6'd0, raw_pixel[15:12]}, 4);
      end
      pftb_pkg::FMT_A8L8: begin
        pixel.red   = b0;
        pixel.green = b0;
        pixel.blue  = b0;
        pixel.alpha = b1;
      end
      pftb_pkg::FMT_A8: begin
        pixel.alpha = b0;
      end
      pftb_pkg::FMT_L8: begin
        pixel.red   = b0;
        pixel.green = b0;
        pixel.blue  = b0;
        pixel.alpha = 8'hff;
      end
      default: begin
        pixel = '0;
      end
    endcase
  end

endmodule

### rtl/pixel_format_to_bgra8.sv
// Converts a stream of raw source pixels to 8-bit blue, green, red and alpha, one
// pixel per clock. The source layout comes from the pixel_format register at byte
// address 0 of the register port; codes 13 to 15 give an all-zero pixel. A beat
// taken on the input passes through the input register and then the result
// register to the output, and with the output ready the block takes a new beat
// in every cycle. Change the format only while no beats are in flight.
module pixel_format_to_bgra8 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_pixel[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // blue[7:0], green[15:8], red[23:16], alpha[31:24]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [pftb_pkg::FmtWidth-1:0] pixel_format;
  logic                          in_valid;
  logic [31:0]                   in_pixel;
  logic                          out_valid;
  pftb_pkg::bgra_t               out_pixel;
  pftb_pkg::bgra_t               conv_pixel;
  logic                          out_load;
  logic                          in_load;

  pftb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_format (pixel_format)
  );

  pftb_convert u_convert (
    .pixel_format (pixel_format),
    .raw_pixel    (in_pixel),
    .pixel        (conv_pixel)
  );

  assign out_load      = !out_valid || m_axis_tready;
  assign in_load       = !in_valid || out_load;
  assign s_axis_tready = in_load;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_axis_tvalid) begin
      in_pixel <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_pixel <= conv_pixel;
    end
  end

endmodule

### rtl/pftb_checker.sv
module pftb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [31:0] prdata,
  input logic        pready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output beat changed");

  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("accepted beat did not reach the output");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output");

  a_reg_port: assert property (@(posedge clk) pready && (prdata[31:4] == 28'd0))
    else $error("register port read data or ready wrong");

endmodule

bind pixel_format_to_bgra8 pftb_checker u_pftb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .prdata        (prdata),
  .pready        (pready)
);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned Segments   = 42;
  localparam int unsigned SegBeats   = 25;
  localparam int unsigned DirCount   = 23;
  localparam logic [2:0]  AddrFmt    = 3'(4 * pftb_pkg::RegFmtIndex);
  localparam logic [2:0]  AddrSpare  = 3'(4 * (pftb_pkg::RegFmtIndex + 1));

  class bgra_checker;
    pftb_pkg::bgra_t expected_pixels[$];
    int unsigned     errors;
    int unsigned     pixels_in;
    int unsigned     beats_out;

    function logic [7:0] scale(logic [31:0] v, int unsigned n);
      logic [31:0] m;
      m = (32'd1 << n) - 32'd1;
      v = v & m;
      return 8'((v * 32'd510 + m) / (32'd2 * m));
    endfunction

    function pftb_pkg::bgra_t convert_pixel(logic [3:0] f, logic [31:0] p);
      pftb_pkg::bgra_t px;
      px = '0;
      case (f)
        pftb_pkg::FMT_ARGB8, pftb_pkg::FMT_XRGB8: begin
          px.blue  = p[7:0];
          px.green = p[15:8];
          px.red   = p[23:16];
          px.alpha = (f == pftb_pkg::FMT_XRGB8) ? 8'hff : p[31:24];
        end
        pftb_pkg::FMT_ABGR8, pftb_pkg::FMT_XBGR8: begin
          px.red   = p[7:0];
          px.green = p[15:8];
          px.blue  = p[23:16];
          px.alpha = (f == pftb_pkg::FMT_XBGR8) ? 8'hff : p[31:24];
        end
        pftb_pkg::FMT_A2RGB10: begin
          px.red   = scale(p >> 20, 10);
          px.green = scale(p >> 10, 10);
          px.blue  = scale(p, 10);
          px.alpha = scale(p >> 30, 2);
        end
        pftb_pkg::FMT_A2BGR10: begin
          px.red   = scale(p, 10);
          px.green = scale(p >> 10, 10);
          px.blue  = scale(p >> 20, 10);
          px.alpha = scale(p >> 30, 2);
        end
        pftb_pkg::FMT_RGB565: begin
          px.red   = scale(p >> 11, 5);
          px.green = scale(p >> 5, 6);
          px.blue  = scale(p, 5);
          px.alpha = 8'hff;
        end
        pftb_pkg::FMT_A1RGB5, pftb_pkg::FMT_X1RGB5: begin
          px.red   = scale(p >> 10, 5);
          px.green = scale(p >> 5, 5);
          px.blue  = scale(p, 5);
          px.alpha = (f == pftb_pkg::FMT_X1RGB5 || p[15]) ? 8'hff : 8'h00;
        end
        pftb_pkg::FMT_ARGB4: begin
          px.red   = scale(p >> 8, 4);
          px.green = scale(p >> 4, 4);
          px.blue  = scale(p, 4);
          px.alpha = scale(p >> 12, 4);
        end
        pftb_pkg::FMT_A8L8: begin
          px.red   = p[7:0];
          px.green = p[7:0];
          px.blue  = p[7:0];
          px.alpha = p[15:8];
        end
        pftb_pkg::FMT_A8: begin
          px.alpha = p[7:0];
        end
        pftb_pkg::FMT_L8: begin
          px.red   = p[7:0];
          px.green = p[7:0];
          px.blue  = p[7:0];
          px.alpha = 8'hff;
        end
        default: begin
          px = '0;
        end
      endcase
      return px;
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= ReportMax) begin
        $display("[%0t] mismatch in %s: expected %h, got %h", $realtime, what, want, got);
      end
    endfunction

    function void note_pixel(logic [3:0] f, logic [31:0] raw);
      expected_pixels.push_back(convert_pixel(f, raw));
      pixels_in++;
    endfunction

    function void check_beat(pftb_pkg::bgra_t got);
      pftb_pkg::bgra_t want;
      beats_out++;
      if (expected_pixels.size() == 0) begin
        report("unexpected output beat", '0, got);
      end else begin
        want = expected_pixels.pop_front();
        if (got.blue  !== want.blue)  report("blue",  want.blue,  got.blue);
        if (got.green !== want.green) report("green", want.green, got.green);
        if (got.red   !== want.red)   report("red",   want.red,   got.red);
        if (got.alpha !== want.alpha) report("alpha", want.alpha, got.alpha);
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bgra_checker sb;
  logic [3:0]  cur_fmt = pftb_pkg::FMT_ARGB8;
  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  int unsigned fmt_writes = 0;
  int unsigned quiet_cycles = 0;

  int unsigned idle_src[4]  = '{0, 88, 0, 31};
  int unsigned idle_sink[4] = '{0, 0, 88, 31};

  logic [3:0] dir_fmt[DirCount] = '{
    pftb_pkg::FMT_ARGB8, pftb_pkg::FMT_ARGB8, pftb_pkg::FMT_ARGB8, pftb_pkg::FMT_XRGB8,
    pftb_pkg::FMT_ABGR8, pftb_pkg::FMT_XBGR8, pftb_pkg::FMT_A2RGB10, pftb_pkg::FMT_A2RGB10,
    pftb_pkg::FMT_A2BGR10, pftb_pkg::FMT_RGB565, pftb_pkg::FMT_RGB565, pftb_pkg::FMT_RGB565,
    pftb_pkg::FMT_A1RGB5, pftb_pkg::FMT_A1RGB5, pftb_pkg::FMT_X1RGB5, pftb_pkg::FMT_ARGB4,
    pftb_pkg::FMT_A8L8, pftb_pkg::FMT_A8, pftb_pkg::FMT_L8, 4'd13, 4'd14, 4'd15, 4'd15
  };
  logic [31:0] dir_raw[DirCount] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h8040_2010, 32'h8040_2010, 32'h8040_2010,
    32'h00ff_ffff, 32'hffff_ffff, 32'h4010_0401, 32'hc00f_fc00, 32'hffff_0000,
    32'h0000_ffff, 32'h0000_f81f, 32'h0000_8000, 32'h0000_7fff, 32'h0000_ffff,
    32'h0000_f0a5, 32'hffff_34c2, 32'hffff_ff7e, 32'hffff_ff5a, 32'hffff_ffff,
    32'hffff_ffff, 32'h1234_5678, 32'h0000_0000
  };

  pixel_format_to_bgra8 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_pixel(cur_fmt, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Timeout: no beat moved for %0d cycles.", StallLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_pixel(input logic [31:0] raw);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom();
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (write && addr == AddrFmt) cur_fmt = wdata[3:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_format(input logic [3:0] f, input bit poke_spare);
    logic [31:0] rd;
    settle();
    apb_access(1'b1, AddrFmt, {28'($urandom()), f}, rd);
    if (poke_spare) apb_access(1'b1, AddrSpare, $urandom(), rd);
    apb_access(1'b0, AddrFmt, '0, rd);
    if (rd !== 32'(cur_fmt)) sb.report("format readback", 32'(cur_fmt), rd);
    fmt_writes++;
  endtask

  initial begin
    logic [31:0] raw;
    int unsigned mode;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DirCount; i++) begin
      if (i == 0 || dir_fmt[i] != dir_fmt[i - 1]) begin
        set_format(dir_fmt[i], dir_fmt[i] == pftb_pkg::FMT_L8);
      end
      send_pixel(dir_raw[i]);
    end

    for (int seg = 0; seg < Segments; seg++) begin
      mode = seg % 4;
      set_format((seg < 16) ? 4'((seg * 7) % 16) : 4'($urandom_range(0, 15)),
                 $urandom_range(0, 7) == 0);
      src_idle   = idle_src[mode];
      sink_stall = idle_sink[mode];
      for (int k = 0; k < SegBeats; k++) begin
        raw = $urandom();
        if ($urandom_range(0, 7) == 0) raw = $urandom_range(0, 1) ? '1 : '0;
        send_pixel(raw);
      end
    end

    settle();
    $display("Converted %0d pixels and checked %0d output beats over %0d format settings,",
             sb.pixels_in, sb.beats_out, fmt_writes);
    $display("including the unused codes, with source gaps and sink stalls mixed in.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("Mismatches: %0d", sb.errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
